>>> design/hpsc_pkg.sv
package hpsc_pkg;

   localparam int TIME_BITS = 32;

   localparam logic [1:0] OP_BUTTON = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_PASS   = 2'd2;

   localparam logic [2:0] REG_MIN_WATTS   = 3'd0;
   localparam logic [2:0] REG_MAX_WATTS   = 3'd1;
   localparam logic [2:0] REG_LOW_BATTERY = 3'd2;
   localparam logic [2:0] REG_CLICK_STEP  = 3'd3;
   localparam logic [2:0] REG_FINE_STEP   = 3'd4;
   localparam logic [2:0] REG_COARSE_STEP = 3'd5;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_WEAK  = 2'd3;

   localparam logic [2:0] STATUS_IDLE   = 3'd0;
   localparam logic [2:0] STATUS_FIRING = 3'd4;

   localparam logic [16:0] RESET_WATTS = 17'd20000;

   typedef struct packed {
      logic [1:0]  operation;
      logic [1:0]  button_id;
      logic [2:0]  button_state;
      logic [15:0] resistance_mohm;
      logic [12:0] battery_mv;
      logic [1:0]  atomizer_error;
   } req_type;

   typedef struct packed {
      logic [15:0] output_voltage_mv;
      logic [16:0] watts_mw;
      logic        heater_on;
      logic        menu_mode;
      logic [2:0]  status;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // register the request and apply the state update
      logic sqrt_init; // start the root of the latched product
      logic sqrt_step; // one root iteration
      logic finish;    // apply rounding and slew, write the result
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic is_pass;
   } sts_type;

endpackage

>>> design/heater_power_setpoint_controller.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_data (req_type)
// rsp       out        rsp_valid/rsp_stall  rsp_data (rsp_type)
// csr       in         csr_write            csr_index, csr_data
//
// One item at a time. Events, ticks and unknown operations go through the load
// and done states; a control pass also runs the root unit, which
// retires two bits of the 33-bit product per cycle. Reset is synchronous and
// restores the configuration, state, voltage and valid registers; the request
// latch, root unit and output register are not reset. The result sits in an
// output register, so a stalled result holds back only the next item's final write.
module heater_power_setpoint_controller
   import hpsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences load, root and result; the datapath holds state.
   hpsc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   hpsc_datapath u_datapath (
      .clock, .reset, .req_data, .csr_write, .csr_index, .csr_data, .cmd, .sts, .rsp_data
   );

endmodule

>>> design/hpsc_ctrl.sv
module hpsc_ctrl
   import hpsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_ROOT = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       take;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (sts.is_pass) begin
               cmd.sqrt_init = 1'b1;
               state_in      = S_ROOT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ROOT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_done) state_in = S_DONE;
         end
         S_DONE: begin
            // Wait until the output register is free before overwriting it.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/hpsc_datapath.sv
module hpsc_datapath
   import hpsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     rsp_data
);

   logic [16:0] min_ff, max_ff;
   logic [12:0] lowbat_ff;
   logic [11:0] click_ff, fine_ff, coarse_ff;

   logic [TIME_BITS-1:0] tick_ff;
   logic [7:0]           pcount_ff [3];
   logic [2:0]           down_ff;
   logic [TIME_BITS-1:0] tlast_ff [3];
   logic [16:0]          watts_ff;
   logic [15:0]          volt_ff;
   logic                 heat_ff, mode_ff, adjust_ff;
   logic [2:0]           lstat_ff;

   logic       pass_ff;
   logic [15:0] res_ff;

   // Root unit state.
   logic [32:0] rad_ff;
   logic [32:0] root_ff;
   logic [33:0] bit_ff;

   rsp_type out_ff;

   function automatic logic [16:0] clamp(input logic [17:0] v, input logic [16:0] lo,
                                         input logic [16:0] hi);
      if (v > {1'b0, hi}) return hi;
      if (v < {1'b0, lo}) return lo;
      return v[16:0];
   endfunction

   // Configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= 17'd1000;
         max_ff    <= 17'd75000;
         lowbat_ff <= 13'd2400;
         click_ff  <= 12'd100;
         fine_ff   <= 12'd25;
         coarse_ff <= 12'd350;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_WATTS:   min_ff    <= csr_data;
            REG_MAX_WATTS:   max_ff    <= csr_data;
            REG_LOW_BATTERY: lowbat_ff <= csr_data[12:0];
            REG_CLICK_STEP:  click_ff  <= csr_data[11:0];
            REG_FINE_STEP:   fine_ff   <= csr_data[11:0];
            REG_COARSE_STEP: coarse_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // State update for one request, all in the load cycle.
   logic [TIME_BITS-1:0] el [3];
   logic [7:0]           pc_in [3];
   logic [2:0]           down_in;
   logic [TIME_BITS-1:0] tl_in [3];
   logic [16:0]          w_in;
   logic                 heat_in, mode_in, adj_in, fire_ok;
   logic [2:0]           ls_in;
   logic [TIME_BITS-1:0] tick_in;
   logic [11:0]          step;
   logic [1:0]           id;
   logic [2:0]           st;

   always_comb begin
      id      = req_data.button_id;
      st      = req_data.button_state;
      tick_in = tick_ff;
      down_in = down_ff;
      w_in    = watts_ff;
      heat_in = heat_ff;
      mode_in = mode_ff;
      adj_in  = adjust_ff;
      ls_in   = lstat_ff;
      step    = '0;
      for (int i = 0; i < 3; i++) begin
         pc_in[i] = pcount_ff[i];
         tl_in[i] = tlast_ff[i];
         el[i]    = tick_ff - tlast_ff[i];
      end
      fire_ok = (el[0] > 40) && (req_data.battery_mv > lowbat_ff);
      case (req_data.operation)
         OP_BUTTON: begin
            if (id != 2'd3) begin
               tl_in[id] = tick_ff;
               if (st[id]) begin
                  if (pcount_ff[id] != 8'd255) pc_in[id] = pcount_ff[id] + 8'd1;
                  down_in[id] = 1'b1;
                  if (adjust_ff && id == 2'd1 && st == 3'd2)
                     w_in = clamp({1'b0, watts_ff} + 18'(click_ff), min_ff, max_ff);
                  if (adjust_ff && id == 2'd2 && st == 3'd4)
                     w_in = clamp((watts_ff > 17'(click_ff)) ?
                                  {1'b0, watts_ff} - 18'(click_ff) : 18'd0,
                                  min_ff, max_ff);
               end else begin
                  down_in[id] = 1'b0;
               end
            end
         end
         OP_TICK: tick_in = tick_ff + 1'b1;
         OP_PASS: begin
            if (st == 3'd3 || st == 3'd5 || st >= 3'd6) adj_in = 1'b0;
            else adj_in = !mode_ff;
            if (pcount_ff[0] == 8'd3 && down_ff[0] && el[0] < 20) mode_in = !mode_ff;
            if (!heat_ff && st == 3'd1 && down_ff[0] && req_data.resistance_mohm != 0 &&
                req_data.atomizer_error == ERR_OK && fire_ok && !mode_in)
               heat_in = 1'b1;
            else if ((heat_ff && !st[0]) || !fire_ok)
               heat_in = 1'b0;
            for (int i = 0; i < 3; i++) begin
               if (el[i] > 60) pc_in[i] = 8'd0;
            end
            // Up is applied before down, as in the pass order.
            if (down_ff[1] && adj_in && !mode_in) begin
               if (el[1] > 60 && el[1] < 180) step = fine_ff;
               else if (el[1] > 180) step = coarse_ff;
               if (step != 0) w_in = clamp({1'b0, w_in} + 18'(step), min_ff, max_ff);
            end
            step = '0;
            if (down_ff[2] && adj_in && !mode_in) begin
               if (el[2] > 60 && el[2] < 180) step = fine_ff;
               else if (el[2] > 180) step = coarse_ff;
               if (step != 0)
                  w_in = clamp((w_in > 17'(step)) ? {1'b0, w_in} - 18'(step) : 18'd0,
                               min_ff, max_ff);
            end
            w_in = clamp({1'b0, w_in}, min_ff, max_ff);
            if (req_data.atomizer_error != ERR_OK) ls_in = {1'b0, req_data.atomizer_error};
            else ls_in = heat_in ? STATUS_FIRING : STATUS_IDLE;
            if (req_data.atomizer_error == ERR_WEAK) down_in[0] = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         down_ff   <= '0;
         watts_ff  <= RESET_WATTS;
         heat_ff   <= 1'b0;
         mode_ff   <= 1'b0;
         adjust_ff <= 1'b1;
         lstat_ff  <= STATUS_IDLE;
         for (int i = 0; i < 3; i++) begin
            pcount_ff[i] <= '0;
            tlast_ff[i]  <= '0;
         end
      end else if (cmd.load) begin
         tick_ff   <= tick_in;
         down_ff   <= down_in;
         watts_ff  <= w_in;
         heat_ff   <= heat_in;
         mode_ff   <= mode_in;
         adjust_ff <= adj_in;
         lstat_ff  <= ls_in;
         for (int i = 0; i < 3; i++) begin
            pcount_ff[i] <= pc_in[i];
            tlast_ff[i]  <= tl_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pass_ff <= (req_data.operation == OP_PASS);
         res_ff  <= req_data.resistance_mohm;
      end
   end

   // Product taken in the cycle after load, then a bit-pair root of 17 steps.
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rad_ff  <= 33'(watts_ff) * 33'(res_ff);
         root_ff <= '0;
         bit_ff  <= 34'h1_0000_0000;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, rad_ff} >= {1'b0, root_ff} + bit_ff) begin
            rad_ff  <= 33'({1'b0, rad_ff} - {1'b0, root_ff} - bit_ff);
            root_ff <= 33'(({1'b0, root_ff} >> 1) + bit_ff);
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // The step with the lowest bit pair is the last one.
   assign sts.sqrt_done = cmd.sqrt_step && (bit_ff == 34'd1);
   assign sts.is_pass   = pass_ff;

   // Rounding to 10 mV: root / 10 via reciprocal on an 18-bit value.
   logic [17:0] rnd;
   logic [35:0] qmul;
   logic [17:0] quot;
   logic [21:0] target;
   logic [15:0] want, tv;

   always_comb begin
      rnd  = root_ff[17:0] + 18'd5;
      qmul = 36'(rnd) * 36'd52429;
      quot = 18'(qmul >> 19);
      if (18'(quot * 18'd10) > rnd) quot = quot - 18'd1;
      target = 22'(quot) * 22'd10;
      tv = (target > 22'd65535) ? 16'hFFFF : target[15:0];
      want = tv;
      if (tv != volt_ff && heat_ff) begin
         if (tv < volt_ff) want = volt_ff - ((volt_ff >= 16'd10) ? 16'd10 : 16'd0);
         else want = (volt_ff > 16'd65435) ? 16'hFFFF : volt_ff + 16'd100;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) volt_ff <= '0;
      else if (cmd.finish && pass_ff) volt_ff <= want;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_ff.output_voltage_mv <= pass_ff ? want : volt_ff;
         out_ff.watts_mw          <= watts_ff;
         out_ff.heater_on         <= heat_ff;
         out_ff.menu_mode         <= mode_ff;
         out_ff.status            <= lstat_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule
